/* hdl/second_mode_finder_top_macros.svh */
// assertion macros used by the checker file
`ifndef SECOND_MODE_FINDER_TOP_MACROS_SVH
`define SECOND_MODE_FINDER_TOP_MACROS_SVH

// clocked property, disabled while the active-low reset is low
`define SMF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("smf assertion failed");

// condition that must never be seen
`define SMF_NEVER(label, clk, rst_n, cond) \
    `SMF_ASSERT(label, clk, rst_n, !(cond))

`endif

/* hdl/smf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_pkg
// Shared types and defaults of the second mode finder.
// ----------------------------------------------------------------------------
package smf_pkg;

    // width of one sample value on the input port
    localparam int SAMPLE_W = 8;

    // default sizes
    localparam int DEF_VALUE_BINS = 256;
    localparam int DEF_MAX_ITEMS  = 256;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_DRAIN,
        ST_REPORT
    } t_state;

endpackage

/* hdl/second_mode_finder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// second_mode_finder_top
// Histogram of a set of samples; reports the smallest value whose count is
// the highest count strictly below the maximum count.
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// command   in         start high, busy low i_sample_value, i_last_item
// result    out        o_valid strobe       o_found, o_second_value
//
// a sample is a histogram read, then write-back of the count
// a sample with i_last_item adds a scan, one read per bin
// through the histogram read port, then drain and report
// the scan zeroes each bin as it passes, ready for the next set
// after reset busy stays high while the histogram clears
// the result strobe lasts one cycle; the receiver cannot stall it
// ----------------------------------------------------------------------------
module second_mode_finder_top #(
    parameter int VALUE_BINS = smf_pkg::DEF_VALUE_BINS,
    parameter int MAX_ITEMS  = smf_pkg::DEF_MAX_ITEMS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic [smf_pkg::SAMPLE_W-1:0]  i_sample_value,
    input  logic                          i_last_item,
    output logic                          busy,
    output logic                          o_valid,
    output logic                          o_found,
    output logic [smf_pkg::SAMPLE_W-1:0]  o_second_value
);
    import smf_pkg::*;

    localparam int AW = (VALUE_BINS > 1) ? $clog2(VALUE_BINS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam logic [AW-1:0] LAST_BIN = AW'(VALUE_BINS - 1);
    localparam logic [CW-1:0] ITEM_LIMIT = CW'(MAX_ITEMS);

    // histogram store
    logic [CW-1:0] mem [VALUE_BINS];
    logic [CW-1:0] r_rd_data;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [CW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;

    // control registers
    t_state        r_state,    n_state;
    logic [AW-1:0] r_scan_idx, n_scan_idx;
    logic [CW-1:0] r_item_cnt, n_item_cnt;
    logic          r_pv,       n_pv;

    // payload registers
    logic [AW-1:0] r_idx,    n_idx;
    logic          r_cnt_en, n_cnt_en;
    logic          r_last,   n_last;
    logic [AW-1:0] r_pidx,   n_pidx;
    logic [CW-1:0] r_top,    n_top;
    logic [AW-1:0] r_tv,     n_tv;
    logic [CW-1:0] r_rc,     n_rc;
    logic [AW-1:0] r_rv,     n_rv;

    logic          in_range;

    assign in_range = (32'(i_sample_value) < 32'(VALUE_BINS));

    // histogram with one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[mem_raddr];
    end

    // state register and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_scan_idx <= '0;
            r_item_cnt <= '0;
            r_pv       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_scan_idx <= n_scan_idx;
            r_item_cnt <= n_item_cnt;
            r_pv       <= n_pv;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_cnt_en <= n_cnt_en;
        r_last   <= n_last;
        r_pidx   <= n_pidx;
        r_top    <= n_top;
        r_tv     <= n_tv;
        r_rc     <= n_rc;
        r_rv     <= n_rv;
    end

    // sequencer and shared compare unit
    always_comb begin
        n_state    = r_state;
        n_scan_idx = r_scan_idx;
        n_item_cnt = r_item_cnt;
        n_pv       = 1'b0;
        n_idx      = r_idx;
        n_cnt_en   = r_cnt_en;
        n_last     = r_last;
        n_pidx     = r_pidx;
        n_top      = r_top;
        n_tv       = r_tv;
        n_rc       = r_rc;
        n_rv       = r_rv;
        mem_we     = 1'b0;
        mem_waddr  = r_pidx;
        mem_wdata  = '0;
        mem_raddr  = r_scan_idx;

        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_scan_idx;
                if (r_scan_idx == LAST_BIN) begin
                    n_scan_idx = '0;
                    n_state    = ST_IDLE;
                end else begin
                    n_scan_idx = r_scan_idx + 1'b1;
                end
            end
            ST_IDLE: begin
                mem_raddr = AW'(i_sample_value);
                if (start) begin
                    n_idx    = AW'(i_sample_value);
                    n_cnt_en = in_range && (r_item_cnt < ITEM_LIMIT);
                    n_last   = i_last_item;
                    n_state  = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // write back the incremented count
                mem_we    = r_cnt_en;
                mem_waddr = r_idx;
                mem_wdata = CW'(r_rd_data + 1'b1);
                if (r_cnt_en) begin
                    n_item_cnt = CW'(r_item_cnt + 1'b1);
                end
                if (r_last) begin
                    n_top   = '0;
                    n_tv    = '0;
                    n_rc    = '0;
                    n_rv    = '0;
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                n_pv   = 1'b1;
                n_pidx = r_scan_idx;
                if (r_scan_idx == LAST_BIN) begin
                    n_scan_idx = '0;
                    n_state    = ST_DRAIN;
                end else begin
                    n_scan_idx = r_scan_idx + 1'b1;
                end
            end
            ST_DRAIN: begin
                n_state = ST_REPORT;
            end
            ST_REPORT: begin
                n_item_cnt = '0;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // one bin per cycle: track top and runner-up, zero the bin behind
        if (r_pv) begin
            mem_we    = 1'b1;
            mem_waddr = r_pidx;
            mem_wdata = '0;
            if (r_rd_data > r_top) begin
                n_top = r_rd_data;
                n_tv  = r_pidx;
                n_rc  = r_top;
                n_rv  = r_tv;
            end else if ((r_rd_data != r_top) && (r_rd_data > r_rc)) begin
                n_rc = r_rd_data;
                n_rv = r_pidx;
            end
        end
    end

    // result ports
    assign busy           = (r_state != ST_IDLE);
    assign o_valid        = (r_state == ST_REPORT);
    assign o_found        = (r_rc != '0);
    assign o_second_value = o_found ? SAMPLE_W'(r_rv) : '0;

endmodule

/* hdl/smf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_checker
// Port-level checks of the second mode finder, bound to the top level.
// ----------------------------------------------------------------------------
`include "second_mode_finder_top_macros.svh"

module smf_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_valid,
    input logic                          o_found,
    input logic [smf_pkg::SAMPLE_W-1:0]  o_second_value
);
    import smf_pkg::*;

    // an accepted transfer occupies the block in the next cycle
    `SMF_ASSERT(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy)
    // a result appears only while the block is working
    `SMF_ASSERT(a_valid_busy, i_clk, i_rst_n, o_valid |-> busy)
    // the result strobe lasts one cycle
    `SMF_ASSERT(a_valid_pulse, i_clk, i_rst_n, o_valid |=> !o_valid)
    // no value is reported without a runner-up
    `SMF_NEVER(a_value_zero, i_clk, i_rst_n, o_valid && !o_found && (o_second_value != '0))

endmodule

bind second_mode_finder_top smf_checker u_smf_checker (.*);
